// ===== rtl/core/kcl_pkg.sv =====
// Package for the keypad code lock core: key codes, menu and event codes,
// register indexes, reset values and the payload structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address is four times the index).
  localparam logic REG_LIGHT_THRESHOLD = 1'b0;
  localparam logic REG_FAIL_LIMIT      = 1'b1;

  localparam logic [9:0] LIGHT_THRESHOLD_RST = 10'd750;
  localparam logic [2:0] FAIL_LIMIT_RST      = 3'd2;

  localparam logic MODE_KEY   = 1'b0;
  localparam logic MODE_LIGHT = 1'b1;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_A         = 4'd10;
  localparam logic [3:0] KEY_B         = 4'd11;
  localparam logic [3:0] KEY_D         = 4'd13;
  localparam logic [3:0] KEY_STAR      = 4'd14;

  typedef enum logic [2:0] {
    MENU_IDLE   = 3'd0,
    MENU_ENTER  = 3'd1,
    MENU_CHANGE = 3'd2,
    MENU_OLD    = 3'd3,
    MENU_NEW    = 3'd4
  } menu_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OPENED  = 3'd1,
    EV_WRONG   = 3'd2,
    EV_ALARM   = 3'd3,
    EV_OLD_OK  = 3'd4,
    EV_OLD_BAD = 3'd5,
    EV_CHANGED = 3'd6,
    EV_TAMPER  = 3'd7
  } event_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] key_code;
    logic [9:0] light_level;
  } item_t;

  typedef struct packed {
    logic [9:0] light_threshold;
    logic [2:0] fail_limit;
  } cfg_t;

  // Factory code 2-3-3-5, any further digits zero.
  function automatic logic [3:0] reset_digit(input int unsigned pos);
    logic [3:0] d;
    case (pos)
      0:       d = 4'd2;
      1:       d = 4'd3;
      2:       d = 4'd3;
      3:       d = 4'd5;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kcl_channels.sv =====
// Valid/ready channel interfaces of the keypad code lock core: one for the
// incoming key press or light sample, one for the result. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] key_code;
  logic [9:0] light_level;

  modport source (output valid, output mode, output key_code, output light_level,
                  input ready);
  modport sink   (input valid, input mode, input key_code, input light_level,
                  output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       latch_open;
  logic [2:0] menu_state;
  logic [2:0] digits_entered;

  modport source (output valid, output event_res, output latch_open,
                  output menu_state, output digits_entered, input ready);
  modport sink   (input valid, input event_res, input latch_open,
                  input menu_state, input digits_entered, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kcl_cfg.sv =====
// APB-style configuration registers of the keypad code lock core.
// Depends on kcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcl_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic      [kcl_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output kcl_pkg::cfg_t                   cfg
);

  logic write_en;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_threshold <= kcl_pkg::LIGHT_THRESHOLD_RST;
      cfg.fail_limit      <= kcl_pkg::FAIL_LIMIT_RST;
    end else if (write_en) begin
      case (paddr[2])
        kcl_pkg::REG_LIGHT_THRESHOLD: cfg.light_threshold <= pwdata[9:0];
        kcl_pkg::REG_FAIL_LIMIT:      cfg.fail_limit      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      kcl_pkg::REG_LIGHT_THRESHOLD: prdata = {22'd0, cfg.light_threshold};
      kcl_pkg::REG_FAIL_LIMIT:      prdata = {29'd0, cfg.fail_limit};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/kcl_in_reg.sv =====
// Input register of the keypad code lock core: captures one request and holds
// it until the engine takes it. Depends on kcl_pkg and kcl_channels.
`timescale 1ns / 1ps
`default_nettype none

module kcl_in_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  kcl_in_if.sink       sample,
  input  wire logic    take,
  output logic         valid,
  output kcl_pkg::item_t item
);

  // Nothing is taken while reset is held, so no request can be dropped by it.
  assign sample.ready = !rst && (!valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sample.ready) begin
      valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item.mode        <= sample.mode;
      item.key_code    <= sample.key_code;
      item.light_level <= sample.light_level;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kcl_engine.sv =====
// Lock engine: menu state machine, digit store, code compare, failure and
// tamper tracking, and the result register. Depends on kcl_pkg, kcl_channels.
`timescale 1ns / 1ps
`default_nettype none

module kcl_engine #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kcl_pkg::cfg_t  cfg,
  input  wire logic           item_valid,
  input  wire kcl_pkg::item_t item,
  output logic                take,
  kcl_out_if.source           result
);

  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  kcl_pkg::menu_t menu, menu_next;
  logic [2:0]     digit_count, digit_count_next;
  logic [2:0]     fail_count, fail_count_next;
  logic           legal_open, legal_open_next;
  logic           tamper_sent, tamper_sent_next;
  logic           latch, latch_next;
  logic [3:0]     entry_digits [CODE_DIGITS];
  logic [3:0]     stored_code  [CODE_DIGITS];
  logic [3:0]     merged       [CODE_DIGITS];
  kcl_pkg::event_t ev;

  logic             fire, is_key, is_digit, collecting, do_digit, done, match;
  logic [2:0]       count_inc, fail_inc;
  logic [IDX_W-1:0] idx;

  assign take = !result.valid || result.ready;
  assign fire = item_valid && take;

  assign is_key     = (item.mode == kcl_pkg::MODE_KEY);
  assign is_digit   = (item.key_code <= kcl_pkg::KEY_DIGIT_MAX);
  assign collecting = (menu == kcl_pkg::MENU_ENTER) || (menu == kcl_pkg::MENU_OLD) ||
                      (menu == kcl_pkg::MENU_NEW);
  assign do_digit   = is_key && is_digit && collecting;
  assign count_inc  = digit_count + 3'd1;
  assign done       = ({1'b0, count_inc} >= 4'(CODE_DIGITS)) || (count_inc == 3'd0);
  assign idx        = digit_count[IDX_W-1:0];
  assign fail_inc   = fail_count + 3'd1;

  // The entry as it stands once the current digit is written.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      merged[i] = (IDX_W'(i) == idx) ? item.key_code : entry_digits[i];
      if (merged[i] != stored_code[i]) match = 1'b0;
    end
  end

  // Menu next state.
  always_comb begin
    menu_next = menu;
    if (is_key) begin
      if (is_digit) begin
        if (collecting && done) begin
          case (menu)
            kcl_pkg::MENU_OLD: menu_next = match ? kcl_pkg::MENU_NEW : kcl_pkg::MENU_IDLE;
            kcl_pkg::MENU_NEW: menu_next = kcl_pkg::MENU_IDLE;
            default:           menu_next = menu;
          endcase
        end
      end else begin
        case (item.key_code)
          kcl_pkg::KEY_A:
            if (menu == kcl_pkg::MENU_IDLE) menu_next = kcl_pkg::MENU_ENTER;
          kcl_pkg::KEY_B:
            if (menu == kcl_pkg::MENU_IDLE) menu_next = kcl_pkg::MENU_CHANGE;
          kcl_pkg::KEY_D:
            menu_next = kcl_pkg::MENU_IDLE;
          kcl_pkg::KEY_STAR:
            if (menu == kcl_pkg::MENU_CHANGE) menu_next = kcl_pkg::MENU_OLD;
          default: ;
        endcase
      end
    end
  end

  // Event and the remaining state.
  always_comb begin
    ev               = kcl_pkg::EV_NONE;
    digit_count_next = digit_count;
    fail_count_next  = fail_count;
    legal_open_next  = legal_open;
    tamper_sent_next = tamper_sent;
    latch_next       = latch;
    if (!is_key) begin
      if (item.light_level < cfg.light_threshold && !legal_open && !tamper_sent) begin
        tamper_sent_next = 1'b1;
        ev               = kcl_pkg::EV_TAMPER;
      end
    end else if (item.key_code == kcl_pkg::KEY_D) begin
      digit_count_next = 3'd0;
      latch_next       = 1'b0;
      legal_open_next  = 1'b0;
      tamper_sent_next = 1'b0;
    end else if (do_digit) begin
      digit_count_next = count_inc;
      if (done) begin
        digit_count_next = 3'd0;
        case (menu)
          kcl_pkg::MENU_ENTER: begin
            if (match) begin
              latch_next      = 1'b1;
              legal_open_next = 1'b1;
              ev              = kcl_pkg::EV_OPENED;
            end else if (fail_inc >= cfg.fail_limit) begin
              fail_count_next = 3'd0;
              ev              = kcl_pkg::EV_ALARM;
            end else begin
              fail_count_next = fail_inc;
              ev              = kcl_pkg::EV_WRONG;
            end
          end
          kcl_pkg::MENU_OLD: begin
            if (match) begin
              ev = kcl_pkg::EV_OLD_OK;
            end else begin
              latch_next       = 1'b0;
              legal_open_next  = 1'b0;
              tamper_sent_next = 1'b0;
              ev               = kcl_pkg::EV_OLD_BAD;
            end
          end
          default: begin
            latch_next       = 1'b0;
            legal_open_next  = 1'b0;
            tamper_sent_next = 1'b0;
            ev               = kcl_pkg::EV_CHANGED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu          <= kcl_pkg::MENU_IDLE;
      digit_count   <= 3'd0;
      fail_count    <= 3'd0;
      legal_open    <= 1'b0;
      tamper_sent   <= 1'b0;
      latch         <= 1'b0;
      result.valid  <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_code[i] <= kcl_pkg::reset_digit(i);
      end
    end else begin
      if (fire) begin
        menu        <= menu_next;
        digit_count <= digit_count_next;
        fail_count  <= fail_count_next;
        legal_open  <= legal_open_next;
        tamper_sent <= tamper_sent_next;
        latch       <= latch_next;
        if (do_digit && done && menu == kcl_pkg::MENU_NEW) begin
          for (int i = 0; i < CODE_DIGITS; i++) begin
            stored_code[i] <= merged[i];
          end
        end
      end
      if (fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Entry digits are only read after being written in the same entry.
  always_ff @(posedge clk) begin
    if (fire && do_digit) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (IDX_W'(i) == idx) entry_digits[i] <= item.key_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.event_res      <= ev;
      result.latch_open     <= latch_next;
      result.menu_state     <= menu_next;
      result.digits_entered <= digit_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keypad_code_lock_core.sv =====
// Top level of the keypad code lock core: configuration port, input register
// and lock engine. Depends on kcl_pkg, kcl_channels, kcl_cfg, kcl_in_reg, kcl_engine.
`timescale 1ns / 1ps
`default_nettype none

// Keypad code lock. Every request on the sample channel is either a key press
// (mode 0) or a light sensor sample (mode 1), and it yields exactly one result
// carrying the event code, the latch state, the menu state and the number of
// digits entered so far. The core takes one request per clock cycle while
// results are accepted; a request is registered on entry and its result is
// registered on exit, so the result is presented once the request has passed
// through both registers. The code compare and all state updates happen
// combinationally between those two registers. While a result waits
// on the result channel the input register can still take one more request;
// the sample channel is not ready while reset is held. After reset the stored
// code is 2-3-3-5 (further digits zero), the light threshold is 750 and the
// failure limit is 2. Configuration registers sit at byte address 0 (light
// threshold, 10 bits) and 4 (failure limit, 3 bits) and should be written only
// while no request is in flight.
module keypad_code_lock_core #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic      [kcl_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  kcl_in_if.sink                          sample,
  kcl_out_if.source                       result
);

  kcl_pkg::cfg_t  cfg;
  kcl_pkg::item_t item;
  logic           item_valid;
  logic           take;

  kcl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Holds one request so the channel keeps moving while a result is stalled.
  kcl_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .take   (take),
    .valid  (item_valid),
    .item   (item)
  );

  kcl_engine #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== sim/kcl_lock_checker.sv =====
// Checker for the keypad code lock core: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on kcl_pkg and the channel interfaces in kcl_channels.
`timescale 1ns / 1ps

module kcl_lock_checker #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  kcl_in_if                          sample,
  kcl_out_if                         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [kcl_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         pending,
  output int                         errors,
  output int                         compared
);
  import kcl_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_LIGHT_THRESHOLD = {REG_LIGHT_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_FAIL_LIMIT      = {REG_FAIL_LIMIT, 2'b00};

  typedef struct packed {
    event_t     ev;
    logic       latch;
    menu_t      menu;
    logic [2:0] digits;
  } lock_outcome_t;

  // Shadow of the lock state and of its registers.
  cfg_t       lock_cfg;
  menu_t      menu;
  logic [2:0] digit_count;
  logic [3:0] entry_digits [8];
  logic [3:0] stored_code [8];
  logic [2:0] fail_count;
  logic       legal_open;
  logic       tamper_sent;
  logic       latch;

  lock_outcome_t lock_outcomes [$];
  int            fail_total = 0;
  int            compare_total = 0;

  // Key D, a wrong old code and a completed change all land here.
  function automatic void close_lock();
    menu        = MENU_IDLE;
    digit_count = 3'd0;
    latch       = 1'b0;
    legal_open  = 1'b0;
    tamper_sent = 1'b0;
  endfunction

  function automatic lock_outcome_t next_lock_outcome(input item_t req);
    lock_outcome_t o;
    event_t        ev;
    logic          code_ok;
    ev = EV_NONE;
    if (req.mode == MODE_KEY) begin
      if (req.key_code <= KEY_DIGIT_MAX) begin
        if (menu == MENU_ENTER || menu == MENU_OLD || menu == MENU_NEW) begin
          entry_digits[digit_count] = req.key_code;
          digit_count = digit_count + 3'd1;
          if (digit_count >= CODE_DIGITS || digit_count == 3'd0) begin
            code_ok = 1'b1;
            for (int i = 0; i < CODE_DIGITS && i < 8; i++) begin
              if (entry_digits[i] != stored_code[i]) code_ok = 1'b0;
            end
            case (menu)
              MENU_ENTER: begin
                if (code_ok) begin
                  latch      = 1'b1;
                  legal_open = 1'b1;
                  ev         = EV_OPENED;
                end else begin
                  fail_count = fail_count + 3'd1;
                  if (fail_count >= lock_cfg.fail_limit) begin
                    fail_count = 3'd0;
                    ev         = EV_ALARM;
                  end else begin
                    ev = EV_WRONG;
                  end
                end
                digit_count = 3'd0;
              end
              MENU_OLD: begin
                if (code_ok) begin
                  menu        = MENU_NEW;
                  digit_count = 3'd0;
                  ev          = EV_OLD_OK;
                end else begin
                  close_lock();
                  ev = EV_OLD_BAD;
                end
              end
              default: begin
                for (int i = 0; i < CODE_DIGITS && i < 8; i++) stored_code[i] = entry_digits[i];
                close_lock();
                ev = EV_CHANGED;
              end
            endcase
          end
        end
      end else if (req.key_code == KEY_A) begin
        if (menu == MENU_IDLE) menu = MENU_ENTER;
      end else if (req.key_code == KEY_B) begin
        if (menu == MENU_IDLE) menu = MENU_CHANGE;
      end else if (req.key_code == KEY_D) begin
        close_lock();
      end else if (req.key_code == KEY_STAR) begin
        if (menu == MENU_CHANGE) menu = MENU_OLD;
      end
    end else if (req.light_level < lock_cfg.light_threshold && !legal_open && !tamper_sent) begin
      tamper_sent = 1'b1;
      ev          = EV_TAMPER;
    end
    o.ev     = ev;
    o.latch  = latch;
    o.menu   = menu;
    o.digits = digit_count;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_total++;
    if (fail_total <= 40) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    item_t         req;
    lock_outcome_t want;
    if (rst) begin
      lock_cfg.light_threshold = LIGHT_THRESHOLD_RST;
      lock_cfg.fail_limit      = FAIL_LIMIT_RST;
      fail_count               = 3'd0;
      for (int i = 0; i < 8; i++) stored_code[i] = 4'd0;
      stored_code[0] = 4'd2;
      stored_code[1] = 4'd3;
      stored_code[2] = 4'd3;
      stored_code[3] = 4'd5;
      close_lock();
      lock_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_LIGHT_THRESHOLD) lock_cfg.light_threshold = pwdata[9:0];
        else if (paddr == ADDR_FAIL_LIMIT) lock_cfg.fail_limit = pwdata[2:0];
      end
      if (sample.valid && sample.ready) begin
        req.mode        = sample.mode;
        req.key_code    = sample.key_code;
        req.light_level = sample.light_level;
        lock_outcomes.push_back(next_lock_outcome(req));
      end
      if (result.valid && result.ready) begin
        if (lock_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with event %0d arrived with nothing outstanding",
                                    result.event_res));
        end else begin
          want = lock_outcomes.pop_front();
          compare_total++;
          if (result.event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, expected %0d (%s)",
                                      result.event_res, want.ev, want.ev.name()));
          if (result.latch_open !== want.latch)
            report_mismatch($sformatf("latch_open %0d, expected %0d",
                                      result.latch_open, want.latch));
          if (result.menu_state !== want.menu)
            report_mismatch($sformatf("menu_state %0d, expected %0d (%s)",
                                      result.menu_state, want.menu, want.menu.name()));
          if (result.digits_entered !== want.digits)
            report_mismatch($sformatf("digits_entered %0d, expected %0d",
                                      result.digits_entered, want.digits));
        end
      end
    end
    pending  <= lock_outcomes.size();
    errors   <= fail_total;
    compared <= compare_total;
  end

endmodule

// ===== sim/tb_keypad_code_lock_core.sv =====
// Top of the keypad code lock testbench: clock, reset, request and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on kcl_pkg, kcl_channels, keypad_code_lock_core and kcl_lock_checker.
`timescale 1ns / 1ps

module tb_keypad_code_lock_core;
  import kcl_pkg::*;

  localparam int unsigned CODE_LEN   = 4;
  localparam int          QUIET_MAX  = 1000;
  localparam int          PHASE_REQS = 140;

  // Keys that the package does not name because the core ignores them.
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic [ADDR_W-1:0] ADDR_LIGHT_THRESHOLD = {REG_LIGHT_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_FAIL_LIMIT      = {REG_FAIL_LIMIT, 2'b00};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int pending;
  int errors;
  int compared;

  kcl_in_if  sample_ch ();
  kcl_out_if result_ch ();

  keypad_code_lock_core #(.CODE_DIGITS(CODE_LEN)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // The checker sees exactly what the core sees, including register writes,
  // so it keeps its own copy of the threshold and the failure limit.
  kcl_lock_checker #(.CODE_DIGITS(CODE_LEN)) lock_checker (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .pending  (pending),
    .errors   (errors),
    .compared (compared)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Our own idea of the stored code. It follows the change sequences that we
  // build on purpose; random noise could in principle change the code too, and
  // then correct entries simply turn into wrong ones, which is still valid
  // stimulus since the checker tracks the real state.
  logic [4*CODE_LEN-1:0] lock_code;
  int                    cur_threshold;
  bit                    no_idle;
  int                    reqs_sent;
  int                    settings_used;

  // ---------------------------------------------------------------------------
  // Request side. Each request draws its own gap before valid goes up; when
  // no_idle is set the gap is zero and valid stays high across requests.
  // Inputs change only at rising edges, through nonblocking assignments, and
  // ready is looked at right after the edge, so we see the value the core had
  // when the edge hit.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic m, input logic [3:0] k, input logic [9:0] lvl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.mode        <= m;
    sample_ch.key_code    <= k;
    sample_ch.light_level <= lvl;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    reqs_sent++;
  endtask

  // A key press carries a random light level so that those bits toggle too.
  task automatic press(input logic [3:0] k);
    send_req(MODE_KEY, k, 10'($urandom_range(0, 1023)));
  endtask

  task automatic sense(input logic [9:0] lvl);
    send_req(MODE_LIGHT, 4'($urandom_range(0, 15)), lvl);
  endtask

  // Digit 0 of a code sits in the low nibble.
  task automatic key_in_code(input logic [4*CODE_LEN-1:0] c);
    for (int i = 0; i < CODE_LEN; i++) press(c[4*i +: 4]);
  endtask

  function automatic logic [4*CODE_LEN-1:0] random_code();
    logic [4*CODE_LEN-1:0] c;
    for (int i = 0; i < CODE_LEN; i++) c[4*i +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // Bumps one digit, so the result is guaranteed to differ from the input.
  function automatic logic [4*CODE_LEN-1:0] wrong_code(input logic [4*CODE_LEN-1:0] c);
    int         pos;
    logic [3:0] d;
    pos = $urandom_range(0, CODE_LEN - 1);
    d   = c[4*pos +: 4];
    c[4*pos +: 4] = (d >= KEY_DIGIT_MAX) ? 4'd0 : d + 4'd1;
    return c;
  endfunction

  // Levels near the threshold are the interesting ones: one below is dark,
  // the threshold itself is still bright.
  function automatic logic [9:0] pick_level();
    int lvl;
    case ($urandom_range(0, 3))
      0:       lvl = cur_threshold - 1;
      1:       lvl = cur_threshold;
      2:       lvl = $urandom_range(0, 1023);
      default: lvl = $urandom_range(0, 1) * 1023;
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 1023) lvl = 1023;
    return 10'(lvl);
  endfunction

  // Lowers valid and waits until every predicted result has been taken. The
  // checker's count is registered, so the loop waits for the clock before each
  // look, to make sure the last request is already counted.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes both registers back to back: setup cycle, then access cycle until
  // pready. psel stays high between the two writes, so it is never lowered and
  // raised within one step.
  task automatic write_registers(input int thr, input int lim);
    logic [ADDR_W-1:0] addr [2];
    int                val  [2];
    drain();
    addr[0] = ADDR_LIGHT_THRESHOLD;
    val[0]  = thr;
    addr[1] = ADDR_FAIL_LIMIT;
    val[1]  = lim;
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr[i];
      pwdata  <= DATA_W'(val[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    cur_threshold  = thr;
    settings_used++;
  endtask

  // One phase of random traffic. Half of it is well-formed: open attempts and
  // code changes that mostly start from a clean lock. The rest is sensor samples,
  // raw noise and sequences that are cut off halfway.
  task automatic run_phase(input int count);
    int                    stop_at;
    int                    pick;
    logic [4*CODE_LEN-1:0] nc;
    stop_at = reqs_sent + count;
    while (reqs_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Open attempt: each code is the right one, a wrong one or a random one. The
        // menu stays in entry after a compare, so further codes may follow without another A.
        if ($urandom_range(0, 3) != 0) press(KEY_D);
        press(KEY_A);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       key_in_code(wrong_code(lock_code));
            1:       key_in_code(random_code());
            default: key_in_code(lock_code);
          endcase
        end
        if ($urandom_range(0, 2) == 0) sense(pick_level());
      end else if (pick < 50) begin
        // Code change: old code right most of the time, then a new code.
        press(KEY_D);
        press(KEY_B);
        press(KEY_STAR);
        if ($urandom_range(0, 3) != 0) begin
          key_in_code(lock_code);
          nc = random_code();
          key_in_code(nc);
          lock_code = nc;
        end else begin
          key_in_code(wrong_code(lock_code));
        end
      end else if (pick < 70) begin
        // Sensor samples, often right after a reset so tampering can fire.
        if ($urandom_range(0, 1) != 0) press(KEY_D);
        repeat ($urandom_range(1, 4)) sense(pick_level());
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6))
          send_req(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   10'($urandom_range(0, 1023)));
      end else begin
        // Broken sequence: a start key, a few digits, then something else.
        press(KEY_D);
        if ($urandom_range(0, 1) != 0) begin
          press(KEY_A);
        end else begin
          press(KEY_B);
          if ($urandom_range(0, 2) != 0) press(KEY_STAR);
        end
        repeat ($urandom_range(1, CODE_LEN - 1)) press(4'($urandom_range(0, 9)));
        case ($urandom_range(0, 5))
          0:       press(KEY_D);
          1:       press(KEY_A);
          2:       press(KEY_HASH);
          3:       press(KEY_C);
          4:       press(KEY_STAR);
          default: sense(pick_level());
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready drops for a random number of cycles before each result,
  // except while no_idle is set.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: the run fails when no request, result or register write is taken
  // before quiet_cycles reaches the quiet limit.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_MAX, pending);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    sample_ch.valid       <= 1'b0;
    sample_ch.mode        <= MODE_KEY;
    sample_ch.key_code    <= 4'd0;
    sample_ch.light_level <= 10'd0;
    lock_code      = {4'd5, 4'd3, 4'd3, 4'd2};
    cur_threshold  = LIGHT_THRESHOLD_RST;
    no_idle        = 1'b0;
    reqs_sent      = 0;
    settings_used  = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset values of the registers. Bright and dark
    // extremes; the tamper alarm fires only once until the lock is reset.
    sense(10'd1023);
    sense(10'd0);
    sense(10'd0);
    // Hash and C are ignored in every menu.
    press(KEY_HASH);
    press(KEY_C);
    // Factory code opens the latch; a dark sample after a legal opening is
    // not tampering.
    press(KEY_A);
    key_in_code(lock_code);
    sense(10'd0);
    // Still in entry: a wrong code straight after the opening.
    key_in_code({4'd0, 4'd9, 4'd0, 4'd9});
    // Reset, then change the code: old code, new code 9-8-1-0.
    press(KEY_D);
    press(KEY_B);
    press(KEY_STAR);
    key_in_code(lock_code);
    key_in_code({4'd0, 4'd1, 4'd8, 4'd9});
    lock_code = {4'd0, 4'd1, 4'd8, 4'd9};

    // Random part over several register settings, extremes included. A
    // threshold of 0 never sees dark, 1023 sees dark almost always; a limit
    // of 1 alarms on every wrong code, 7 only after a long run of them.
    write_registers(0, 1);
    run_phase(PHASE_REQS);
    write_registers(1023, 7);
    run_phase(PHASE_REQS);
    write_registers($urandom_range(1, 1022), $urandom_range(1, 7));
    no_idle = 1'b1;
    run_phase(PHASE_REQS / 2);
    no_idle = 1'b0;
    run_phase(PHASE_REQS / 2);
    write_registers(LIGHT_THRESHOLD_RST, FAIL_LIMIT_RST);
    run_phase(PHASE_REQS);
    write_registers($urandom_range(0, 1023), $urandom_range(1, 7));
    run_phase(PHASE_REQS);

    // All requests are in: wait for the last results, then let the clock run on
    // in case something unexpected trails out of the core.
    drain();
    repeat (8) @(posedge clk);

    $display("summary: %0d requests (keys and light samples) over %0d register settings,",
             reqs_sent, settings_used);
    $display("summary: %0d results compared, %0d mismatches", compared, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
